// ===== rtl/triangle_tangent_basis_assert.svh =====
// Assertion macros shared by the tangent basis RTL.
// Users must have signals named clk and rst in scope.
`ifndef TRIANGLE_TANGENT_BASIS_ASSERT_SVH
`define TRIANGLE_TANGENT_BASIS_ASSERT_SVH

// Same-cycle implication.
`define TTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TTB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ttb_pkg.sv =====
// Package for the triangle tangent basis unit: payload and job types.
// No dependencies.
package ttb_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] tex_s;
    logic signed [15:0] tex_t;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] tan_x;
    logic signed [31:0] tan_y;
    logic signed [31:0] tan_z;
    logic signed [31:0] bitan_x;
    logic signed [31:0] bitan_y;
    logic signed [31:0] bitan_z;
    logic               degenerate;
    logic               last_of_triangle;
  } basis_t;

  typedef struct packed {
    logic signed [32:0] e1_x;
    logic signed [32:0] e1_y;
    logic signed [32:0] e1_z;
    logic signed [32:0] e2_x;
    logic signed [32:0] e2_y;
    logic signed [32:0] e2_z;
    logic signed [16:0] d1_s;
    logic signed [16:0] d1_t;
    logic signed [16:0] d2_s;
    logic signed [16:0] d2_t;
  } job_t;

  localparam int unsigned NumComp = 6;
  localparam int unsigned TriVerts = 3;
  localparam logic [1:0] PhaseLast = 2'd2;

endpackage

// ===== rtl/ttb_queue.sv =====
// Two-entry queue of triangle jobs between the front and the back.
// Depends on ttb_pkg.
module ttb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ttb_pkg::job_t push_data,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop,
  output ttb_pkg::job_t pop_data
);
  import ttb_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/ttb_front.sv =====
// Front end: accepts vertices, holds the first two of each triangle and
// forms edge vectors and texcoord deltas on the third. Depends on ttb_pkg.
module ttb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ttb_pkg::vertex_t in_data,
  input  logic             job_full,
  output logic             job_push,
  output ttb_pkg::job_t    job_data
);
  import ttb_pkg::*;

  logic [1:0] phase;
  vertex_t    v0;
  vertex_t    v1;
  logic       xfer;

  assign in_ready = (phase != PhaseLast) || !job_full;
  assign xfer     = in_valid && in_ready;
  assign job_push = xfer && (phase == PhaseLast);

  assign job_data.e1_x = 33'(v1.pos_x) - 33'(v0.pos_x);
  assign job_data.e1_y = 33'(v1.pos_y) - 33'(v0.pos_y);
  assign job_data.e1_z = 33'(v1.pos_z) - 33'(v0.pos_z);
  assign job_data.e2_x = 33'(in_data.pos_x) - 33'(v0.pos_x);
  assign job_data.e2_y = 33'(in_data.pos_y) - 33'(v0.pos_y);
  assign job_data.e2_z = 33'(in_data.pos_z) - 33'(v0.pos_z);
  assign job_data.d1_s = 17'(v1.tex_s) - 17'(v0.tex_s);
  assign job_data.d1_t = 17'(v1.tex_t) - 17'(v0.tex_t);
  assign job_data.d2_s = 17'(in_data.tex_s) - 17'(v0.tex_s);
  assign job_data.d2_t = 17'(in_data.tex_t) - 17'(v0.tex_t);

  always_ff @(posedge clk) begin
    if (xfer && (phase == 2'd0)) begin
      v0 <= in_data;
    end
    if (xfer && (phase == 2'd1)) begin
      v1 <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
    end else if (xfer) begin
      phase <= (phase == PhaseLast) ? 2'd0 : phase + 2'd1;
    end
  end
endmodule

// ===== rtl/ttb_back.sv =====
// Back end: determinant, numerators, one shared restoring divider and the result
// register repeating the basis for three vertices. Needs ttb_pkg, the assert .svh.
module ttb_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_pop,
  input  ttb_pkg::job_t    job_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ttb_pkg::basis_t  out_data
);
  import ttb_pkg::*;
  `include "triangle_tangent_basis_assert.svh"

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DET    = 7'b0000010,
    S_DETSUB = 7'b0000100,
    S_MUL    = 7'b0001000,
    S_SUB    = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t             state;
  job_t               job;
  logic signed [49:0] p0;
  logic signed [49:0] p1;
  logic [34:0]        dmag;
  logic               dneg;
  logic               qneg;
  logic               ovf;
  logic [35:0]        rem;
  logic [31:0]        low;
  logic [31:0]        quo;
  logic [4:0]         cnt;
  logic [2:0]         comp;
  logic [1:0]         ocnt;
  logic               degen;
  logic [31:0]        res [NumComp];

  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [32:0] mul_c;
  logic signed [16:0] mul_d;
  logic signed [34:0] det_c;
  logic signed [50:0] num_c;
  logic [50:0]        nmag;
  logic [64:0]        nn;
  logic [35:0]        dden;
  logic [36:0]        r2;
  logic               qbit;
  logic [31:0]        quo_next;
  logic [31:0]        sat;
  logic               out_xfer;

  always_comb begin
    mul_a = job.e1_x;
    mul_c = job.e2_x;
    case (comp)
      3'd0, 3'd3: begin
        mul_a = job.e1_x;
        mul_c = job.e2_x;
      end
      3'd1, 3'd4: begin
        mul_a = job.e1_y;
        mul_c = job.e2_y;
      end
      3'd2, 3'd5: begin
        mul_a = job.e1_z;
        mul_c = job.e2_z;
      end
      default: begin
        mul_a = job.e1_x;
        mul_c = job.e2_x;
      end
    endcase
    if (comp < 3'd3) begin
      mul_b = job.d2_t;
      mul_d = job.d1_t;
    end else begin
      // Bitangent: e2 * d1.s - e1 * d2.s.
      {mul_a, mul_c} = {mul_c, mul_a};
      mul_b = job.d1_s;
      mul_d = job.d2_s;
    end
  end

  assign det_c = 35'(p0) - 35'(p1);
  assign num_c = 51'(p0) - 51'(p1);
  assign nmag  = num_c[50] ? 51'(-num_c) : 51'(num_c);
  assign dden  = {dmag, 1'b0};
  assign nn    = {1'b0, nmag, 13'd0} + {30'd0, dmag};

  assign r2       = {rem, low[31]};
  assign qbit     = (r2 >= {1'b0, dden});
  assign quo_next = {quo[30:0], qbit};

  always_comb begin
    if (qneg) begin
      sat = (ovf || quo_next > 32'h8000_0000) ? 32'h8000_0000 : 32'(-quo_next);
    end else begin
      sat = (ovf || quo_next[31]) ? 32'h7fff_ffff : quo_next;
    end
  end

  assign job_pop   = (state == S_IDLE) && job_valid;
  assign out_valid = (state == S_OUT);
  assign out_xfer  = out_valid && out_ready;

  assign out_data.tan_x            = res[0];
  assign out_data.tan_y            = res[1];
  assign out_data.tan_z            = res[2];
  assign out_data.bitan_x          = res[3];
  assign out_data.bitan_y          = res[4];
  assign out_data.bitan_z          = res[5];
  assign out_data.degenerate       = degen;
  assign out_data.last_of_triangle = (ocnt == 2'(TriVerts - 1));

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        job <= job_data;
      end
      S_DET: begin
        p0 <= 50'(job.d1_s * job.d2_t);
        p1 <= 50'(job.d1_t * job.d2_s);
      end
      S_DETSUB: begin
        dmag  <= det_c[34] ? 35'(-det_c) : 35'(det_c);
        dneg  <= det_c[34];
        degen <= (det_c == 35'sd0);
        if (det_c == 35'sd0) begin
          for (int i = 0; i < NumComp; i++) begin
            res[i] <= 32'd0;
          end
        end
      end
      S_MUL: begin
        p0 <= 50'(mul_a * mul_b);
        p1 <= 50'(mul_c * mul_d);
      end
      S_SUB: begin
        qneg <= num_c[50] ^ dneg;
        ovf  <= ({3'd0, nn[64:32]} >= dden);
        rem  <= {3'd0, nn[64:32]};
        low  <= nn[31:0];
        quo  <= 32'd0;
      end
      S_DIV: begin
        rem <= qbit ? 36'(r2 - {1'b0, dden}) : r2[35:0];
        low <= {low[30:0], 1'b0};
        quo <= quo_next;
        if (cnt == 5'd31) begin
          res[comp] <= sat;
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= 5'd0;
      comp  <= 3'd0;
      ocnt  <= 2'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            state <= S_DET;
          end
        end
        S_DET: begin
          state <= S_DETSUB;
        end
        S_DETSUB: begin
          comp  <= 3'd0;
          ocnt  <= 2'd0;
          state <= (det_c == 35'sd0) ? S_OUT : S_MUL;
        end
        S_MUL: begin
          state <= S_SUB;
        end
        S_SUB: begin
          cnt   <= 5'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            if (comp == 3'(NumComp - 1)) begin
              state <= S_OUT;
            end else begin
              comp  <= comp + 3'd1;
              state <= S_MUL;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            ocnt <= ocnt + 2'd1;
            if (ocnt == 2'(TriVerts - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TTB_ASSERT_NXT(a_last_ends, out_xfer && out_data.last_of_triangle, !out_valid, "result after last")
  `TTB_ASSERT_IMP(a_degen_zero, out_valid && out_data.degenerate, res[0] == 32'd0 && res[5] == 32'd0, "degenerate not zero")
  `TTB_ASSERT_IMP(a_ocnt_range, out_valid, ocnt != 2'd3, "fourth result of a triangle")
  `TTB_ASSERT_NXT(a_pop_starts, job_pop, state == S_DET, "job taken without starting")
endmodule

// ===== rtl/triangle_tangent_basis.sv =====
// Top level of the triangle tangent basis unit: front, job queue and back.
// Depends on ttb_pkg, ttb_front, ttb_queue and ttb_back.
//
//   channel | direction | payload  | per transfer
//   in      | input     | vertex_t | one vertex
//   out     | output    | basis_t  | one basis; three per triangle
//
// In the back end a triangle passes S_DET and S_DETSUB for the determinant, then for
// each of the six components S_MUL and S_SUB for the numerator and the shared
// one-bit-per-cycle restoring divider, plus three output transfers; a zero
// determinant skips to the output. A new triangle starts after the third result.
// Reset is synchronous and clears the vertex phase, the queue and the state.
// The front keeps taking vertices while the back works, up to two queued triangles.
module triangle_tangent_basis (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ttb_pkg::vertex_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ttb_pkg::basis_t  out_data
);
  import ttb_pkg::*;

  logic job_full;
  logic job_push;
  logic job_valid;
  logic job_pop;
  job_t push_data;
  job_t pop_data;

  ttb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .job_full (job_full),
    .job_push (job_push),
    .job_data (push_data)
  );

  ttb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (push_data),
    .full      (job_full),
    .pop_valid (job_valid),
    .pop       (job_pop),
    .pop_data  (pop_data)
  );

  ttb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule
